// File: hdl/cte_pkg.sv
// shared types, constants and the month table for the calendar to epoch seconds unit
`timescale 1ns / 1ps

package cte_pkg;

  localparam logic [15:0] EPOCH_YEAR         = 16'd1970;
  // leap days in years 1 through 1969
  localparam logic [13:0] LEAPS_BEFORE_EPOCH = 14'd477;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN       = 6'd60;
  localparam logic [6:0]  YEARS_PER_CENTURY  = 7'd100;
  // ceil(2^19 / 25): x / 100 == ((x >> 2) * RECIP_25) >> 19 for 16-bit x
  localparam logic [14:0] RECIP_25           = 15'd20972;
  localparam logic [3:0]  MONTH_IDX_MAR      = 4'd2;
  localparam logic [3:0]  MONTH_IDX_DEC      = 4'd11;
  localparam logic [3:0]  MONTH_DEC          = 4'd12;

  localparam int IN_BYTES  = 6;
  localparam int OUT_BYTES = 6;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cte_in_t;

  typedef struct packed {
    logic [15:0] year;       // clamped year
    logic [13:0] y4;         // (year - 1) / 4
    logic [28:0] leap_prod;  // ((year - 1) >> 2) * RECIP_25
    logic [28:0] year_prod;  // (year >> 2) * RECIP_25
    logic [3:0]  month_idx;  // 0..11
    logic [4:0]  day_m1;
    logic [16:0] hms;        // time of day in seconds
  } cte_s1_t;

  typedef struct packed {
    logic [24:0] yr_days;
    logic [13:0] leaps;
    logic [8:0]  dbm;
    logic        leap_add;
    logic [4:0]  day_m1;
    logic [16:0] hms;
  } cte_s2_t;

  typedef struct packed {
    logic [24:0] days;
    logic [16:0] hms;
  } cte_s3_t;

  typedef struct packed {
    logic [40:0] day_secs;
    logic [16:0] hms;
  } cte_s4_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] idx);
    logic [8:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: hdl/cte_front.sv
// first two pipeline stages: clamping, leap-day counting and year decomposition
`timescale 1ns / 1ps

module cte_front import cte_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  cte_in_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output cte_s2_t out_data
);

  logic    v1, v2;
  logic    en1, en2;
  cte_s1_t r1, r1_next;
  cte_s2_t r2, r2_next;

  logic [15:0] year_c;
  logic [15:0] ym1;
  logic [9:0]  q100;
  logic [7:0]  q400;
  logic [9:0]  yq100;
  logic        rem_zero;
  logic        leap;
  logic [15:0] years;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // stage 1: clamp the date fields, start the divisions by 100, sum the time of day
  always_comb begin
    year_c = (in_data.year < EPOCH_YEAR) ? EPOCH_YEAR : in_data.year;
    ym1    = year_c - 16'd1;
    r1_next.year      = year_c;
    r1_next.y4        = ym1[15:2];
    r1_next.leap_prod = 29'(ym1[15:2]) * 29'(RECIP_25);
    r1_next.year_prod = 29'(year_c[15:2]) * 29'(RECIP_25);
    if (in_data.month == 4'd0) begin
      r1_next.month_idx = 4'd0;
    end else if (in_data.month > MONTH_DEC) begin
      r1_next.month_idx = MONTH_IDX_DEC;
    end else begin
      r1_next.month_idx = in_data.month - 4'd1;
    end
    r1_next.day_m1 = (in_data.day == 5'd0) ? 5'd0 : in_data.day - 5'd1;
    r1_next.hms    = 17'(in_data.hour) * 17'(SECS_PER_HOUR)
                   + 17'(in_data.minute) * 17'(SECS_PER_MIN)
                   + 17'(in_data.second);
  end

  // stage 2: leap days, leap flag, whole-year days, days before the month
  always_comb begin
    q100     = r1.leap_prod[28:19];
    q400     = q100[9:2];
    yq100    = r1.year_prod[28:19];
    rem_zero = (17'(r1.year) == 17'(yq100) * 17'(YEARS_PER_CENTURY));
    leap     = (r1.year[1:0] == 2'd0) && (!rem_zero || (yq100[1:0] == 2'd0));
    years    = r1.year - EPOCH_YEAR;
    r2_next.yr_days  = 25'(years) * 25'(DAYS_PER_YEAR);
    r2_next.leaps    = 14'(15'(r1.y4) - 15'(q100) + 15'(q400) - 15'(LEAPS_BEFORE_EPOCH));
    r2_next.dbm      = days_before_month(r1.month_idx);
    r2_next.leap_add = leap && (r1.month_idx >= MONTH_IDX_MAR);
    r2_next.day_m1   = r1.day_m1;
    r2_next.hms      = r1.hms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) r1 <= r1_next;
    if (en2) r2 <= r2_next;
  end

  assign out_valid = v2;
  assign out_data  = r2;

endmodule

// File: hdl/cte_days.sv
// third pipeline stage: total day count since the epoch
`timescale 1ns / 1ps

module cte_days import cte_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  cte_s2_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output cte_s3_t out_data
);

  logic    v3;
  logic    en3;
  cte_s3_t r3, r3_next;

  assign en3      = !v3 || out_ready;
  assign in_ready = en3;

  always_comb begin
    r3_next.days = in_data.yr_days + 25'(in_data.leaps) + 25'(in_data.dbm)
                 + 25'(in_data.leap_add) + 25'(in_data.day_m1);
    r3_next.hms  = in_data.hms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) r3 <= r3_next;
  end

  assign out_valid = v3;
  assign out_data  = r3;

endmodule

// File: hdl/cte_seconds.sv
// last two pipeline stages: days to seconds, then time of day added
`timescale 1ns / 1ps

module cte_seconds import cte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cte_s3_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [40:0] out_secs
);

  logic        v4, v5;
  logic        en4, en5;
  cte_s4_t     r4, r4_next;
  logic [40:0] r5, r5_next;

  assign en5      = !v5 || out_ready;
  assign en4      = !v4 || en5;
  assign in_ready = en4;

  always_comb begin
    r4_next.day_secs = 41'(in_data.days) * 41'(SECS_PER_DAY);
    r4_next.hms      = in_data.hms;
    r5_next          = r4.day_secs + 41'(r4.hms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) r4 <= r4_next;
    if (en5) r5 <= r5_next;
  end

  assign out_valid = v5;
  assign out_secs  = r5;

endmodule

// File: hdl/calendar_to_epoch_seconds_unit.sv
// top level: gregorian date and time to seconds since 1970-01-01 00:00:00
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: year, month, day, hour, minute, second
// m_*       out  m_tvalid/m_tready  m_tdata: epoch_seconds
//
// five register stages, one transfer accepted per cycle unless a stall backs up to the input
// depth is set by the two divide-by-100 multiplies, which share the first stage, and by the year
// multiply, the day sum, the day multiply and the final 41-bit add, each in a stage of its own
// rst is synchronous and clears only the stage valid bits
// a stall backs up stage by stage; a stage takes new data when it is empty or moves on

module calendar_to_epoch_seconds_unit import cte_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // year[15:0], month[19:16], day[24:20], hour[29:25], minute[35:30],
  // second[41:36], zero pad[47:42]
  input  logic [IN_BYTES*8-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // epoch_seconds[40:0], zero pad[47:41]
  output logic [OUT_BYTES*8-1:0] m_tdata
);

  cte_in_t     in_fields;
  cte_s2_t     front_data;
  cte_s3_t     days_data;
  logic        front_valid, front_ready;
  logic        days_valid, days_ready;
  logic [40:0] secs;

  // unpack the input transfer
  assign in_fields.year   = s_tdata[15:0];
  assign in_fields.month  = s_tdata[19:16];
  assign in_fields.day    = s_tdata[24:20];
  assign in_fields.hour   = s_tdata[29:25];
  assign in_fields.minute = s_tdata[35:30];
  assign in_fields.second = s_tdata[41:36];

  // clamp, leap counting, years times 365
  cte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_fields),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  // sum of all day terms
  cte_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (days_valid),
    .out_ready (days_ready),
    .out_data  (days_data)
  );

  // days to seconds plus time of day, output register
  cte_seconds u_seconds (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (days_valid),
    .in_ready  (days_ready),
    .in_data   (days_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_secs  (secs)
  );

  assign m_tdata = {{(OUT_BYTES*8-41){1'b0}}, secs};

  // the pipeline never holds off input while the output side is free
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled with output ready");

  // input is held off only when a result waits at the output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled without a waiting result");

  // an accepted transfer reaches the output if the output side stays free meanwhile
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
      ##1 m_tready |=> m_tvalid)
    else $error("result missing after pipeline latency");

endmodule

// File: tb/sv/tb_calendar_to_epoch_seconds_unit.sv
// testbench: calendar dates streamed through the epoch seconds unit, checked against a predictor
`timescale 1ns / 1ps

module tb_calendar_to_epoch_seconds_unit;
  import cte_pkg::*;

  localparam int unsigned CLOCK_HIGH   = 6;
  localparam int unsigned CLOCK_LOW    = 6;
  localparam int unsigned IDLE_PERCENT = 23;
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 40;

  typedef struct {
    cte_in_t     date;
    bit          known;
    logic [40:0] value;
  } date_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_BYTES*8-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_BYTES*8-1:0] m_tdata;

  logic [40:0]  epoch_expect_q[$];
  date_row_t    date_rows[$];
  logic [40:0]  want_secs;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  bit           rx_hold_req = 1'b0;
  int unsigned  hold_left = 0;
  int unsigned  cycle_count = 0;
  int unsigned  errors = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_random = 0;

  calendar_to_epoch_seconds_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #CLOCK_LOW clk = 1'b1;
    #CLOCK_HIGH clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] leaps_upto(input logic [63:0] n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic bit is_leap_year(input logic [63:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic logic [63:0] month_offset(input logic [63:0] mon);
    case (mon)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      default: return 334;
    endcase
  endfunction

  function automatic logic [40:0] epoch_of(input cte_in_t d);
    logic [63:0] yr;
    logic [63:0] mon;
    logic [63:0] dom;
    logic [63:0] days;
    logic [63:0] secs;
    yr  = d.year;
    mon = d.month;
    dom = d.day;
    // a year below 1970, a month outside 1..12 and day 0 are clamped, the time of day is not
    if (yr < 1970) yr = 1970;
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    if (dom < 1) dom = 1;
    days = (yr - 1970) * 365 + leaps_upto(yr - 1) - leaps_upto(1969)
         + month_offset(mon) + dom - 1;
    if (mon > 2 && is_leap_year(yr)) days = days + 1;
    secs = days * 86400 + d.hour * 3600 + d.minute * 60 + d.second;
    return secs[40:0];
  endfunction

  // ---------------------------------------------------------------- sender

  // one date offered until accepted; value is the typed-in result when known
  task automatic offer_date(input cte_in_t d, input bit known, input logic [40:0] value);
    while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    // zero pad, second, minute, hour, day, month, year from the top down
    s_tdata  <= {6'b0, d.second, d.minute, d.hour, d.day, d.month, d.year};
    do @(posedge clk); while (!s_tready);
    epoch_expect_q.push_back(known ? value : epoch_of(d));
  endtask

  task automatic add_row(input int unsigned y, input int unsigned mo, input int unsigned dd,
                         input int unsigned h, input int unsigned mi, input int unsigned s,
                         input bit known, input logic [40:0] value);
    date_row_t row;
    row.date.year   = 16'(y);
    row.date.month  = 4'(mo);
    row.date.day    = 5'(dd);
    row.date.hour   = 5'(h);
    row.date.minute = 6'(mi);
    row.date.second = 6'(s);
    row.known       = known;
    row.value       = value;
    date_rows.push_back(row);
  endtask

  task automatic send_random_dates(input int unsigned count);
    cte_in_t     d;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // any bit pattern, clamping and unchecked overflow of the fields
        d.year   = 16'($urandom);
        d.month  = 4'($urandom);
        d.day    = 5'($urandom);
        d.hour   = 5'($urandom);
        d.minute = 6'($urandom);
        d.second = 6'($urandom);
      end else begin
        if (pick < 25) begin
          // around century boundaries, where the leap rules bite
          d.year = 16'($urandom_range(655, 20) * 100 + $urandom_range(2) - 1);
        end else if (pick < 40) begin
          d.year = 16'($urandom_range(2200, 1970));
        end else begin
          d.year = 16'($urandom_range(65535, 1970));
        end
        d.month  = 4'($urandom_range(12, 1));
        d.day    = 5'($urandom_range(31, 1));
        d.hour   = 5'($urandom_range(23, 0));
        d.minute = 6'($urandom_range(59, 0));
        d.second = 6'($urandom_range(59, 0));
      end
      offer_date(d, 1'b0, '0);
      n_random++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // epoch itself and the clamps that fold back onto it
    add_row(1970,  1,  1,  0,  0,  0, 1'b1, 41'd0);
    add_row(   0,  0,  0,  0,  0,  0, 1'b1, 41'd0);
    add_row(1969,  1,  1,  0,  0,  0, 1'b1, 41'd0);
    add_row(1970,  0,  1,  0,  0,  0, 1'b1, 41'd0);
    add_row(1970,  1,  0,  0,  0,  0, 1'b1, 41'd0);
    // time of day fields at all ones, added with their weights
    add_row(1970,  1,  1, 31, 63, 63, 1'b1, 41'd115443);
    // month above twelve acts as december
    add_row(1970, 12,  1,  0,  0,  0, 1'b1, 41'd28857600);
    add_row(1970, 13,  1,  0,  0,  0, 1'b1, 41'd28857600);
    add_row(1970, 15,  1,  0,  0,  0, 1'b1, 41'd28857600);
    // day past month end rolls into march
    add_row(1970,  2, 31,  0,  0,  0, 1'b1, 41'd5270400);
    add_row(1970,  1, 31, 23, 59, 59, 1'b1, 41'd2678399);
    add_row(1971,  1,  1,  0,  0,  0, 1'b1, 41'd31536000);
    add_row(1973,  1,  1,  0,  0,  0, 1'b1, 41'd94694400);
    add_row(2000,  1,  1,  0,  0,  0, 1'b1, 41'd946684800);
    add_row(2038,  1, 19,  3, 14,  7, 1'b1, 41'd2147483647);
    // leap day handling, including the century rules
    add_row(1972,  2, 29,  0,  0,  0, 1'b0, '0);
    add_row(1972,  3,  1,  0,  0,  0, 1'b0, '0);
    add_row(2000,  3,  1, 12,  0,  0, 1'b0, '0);
    add_row(2100,  3,  1,  0,  0,  0, 1'b0, '0);
    add_row(2400, 12, 31, 23, 59, 59, 1'b0, '0);
    // top of the year range and alternating year bit patterns
    add_row(65535, 12, 31, 23, 59, 59, 1'b0, '0);
    add_row(65535, 15, 31, 31, 63, 63, 1'b0, '0);
    add_row(43690, 10, 21, 10, 42, 21, 1'b0, '0);
    add_row(21845,  5, 10, 21, 21, 42, 1'b0, '0);

    foreach (date_rows[i]) offer_date(date_rows[i].date, date_rows[i].known, date_rows[i].value);

    send_random_dates(400);

    // long stretch with both sides always ready
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random_dates(300);

    // receiver holds off while the sender keeps offering, the pipe fills and stalls
    rx_hold_req = 1'b1;
    send_random_dates(100);

    // sender pauses until every result is out
    s_tvalid <= 1'b0;
    do @(posedge clk); while (epoch_expect_q.size() != 0);

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random_dates(900);
    s_tvalid <= 1'b0;

    while (epoch_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("dates sent: %0d directed, %0d random (clamped fields, leap rules, stalls)",
             date_rows.size(), n_random);
    $display("results compared: %0d, mismatches: %0d", n_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_idle_on) begin
      m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest pending date
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (epoch_expect_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %0d", $time, m_tdata[40:0]);
      end else begin
        want_secs = epoch_expect_q.pop_front();
        n_checked++;
        if (m_tdata[40:0] !== want_secs) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: epoch_seconds mismatch, expected %0d, actual %0d",
                     $time, want_secs, m_tdata[40:0]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, epoch_expect_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

// File: calendar_to_epoch_seconds_unit.f
hdl/cte_pkg.sv
hdl/cte_front.sv
hdl/cte_days.sv
hdl/cte_seconds.sv
hdl/calendar_to_epoch_seconds_unit.sv
tb/sv/tb_calendar_to_epoch_seconds_unit.sv
